FILE: rtl/core/rrit_pkg.sv
// Package: constants, types and the arctangent table of the inertia-term pipeline.
`timescale 1ns / 1ps
package rrit_pkg;

  localparam int CordicStepsDefault = 24;
  localparam int CordicStepsMax     = 40;

  // Angle constants in Q28, CORDIC gain in Q30
  localparam logic signed [34:0] PiQ28     = 35'sd843314857;
  localparam logic signed [34:0] TwoPiQ28  = 35'sd1686629713;
  localparam logic signed [34:0] HalfPiQ28 = 35'sd421657428;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;

  localparam logic signed [47:0] SatHi = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SatLo = 48'sh8000_0000_0000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_IXX = 3'd0,
    REG_IXY = 3'd1,
    REG_IYX = 3'd2,
    REG_IYY = 3'd3,
    REG_DT  = 3'd4
  } reg_index_t;

  // Unsigned quotient by shift and subtract, used at elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in Q28, series truncated per term in Q62 then rounded
  function automatic logic signed [34:0] atn(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    acc = 64'd0;
    if (i == 0) begin
      return 35'sd210828714;
    end
    for (int k = 0; k < 32; k++) begin
      if (i * (2 * k + 1) <= 62) begin
        term = udiv64(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
        if ((k & 1) == 1) acc = acc - term;
        else acc = acc + term;
      end
    end
    acc = (acc + (64'd1 << 33)) >> 34;
    return signed'(acc[34:0]);
  endfunction

endpackage

FILE: rtl/core/rrit_cordic.sv
// Pipelined rotation-mode CORDIC with stall, one iteration per stage.
`timescale 1ns / 1ps
module rrit_cordic
  import rrit_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDefault,
  parameter int TagWidth     = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       in_valid,
  input  logic signed [34:0]         in_angle,
  input  logic [TagWidth-1:0]        in_tag,
  output logic                       out_valid,
  output logic signed [33:0]         out_x,
  output logic signed [33:0]         out_y,
  output logic [TagWidth-1:0]        out_tag
);

  logic signed [33:0]  x   [CORDIC_STEPS+1];
  logic signed [33:0]  y   [CORDIC_STEPS+1];
  logic signed [34:0]  z   [CORDIC_STEPS+1];
  logic [TagWidth-1:0] tag [CORDIC_STEPS+1];
  logic                vld [CORDIC_STEPS+1];

  assign x[0]   = GainQ30;
  assign y[0]   = '0;
  assign z[0]   = in_angle;
  assign tag[0] = in_tag;
  assign vld[0] = in_valid;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [34:0] Atn = atn(i);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (advance) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        tag[i+1] <= tag[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - Atn;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + Atn;
        end
      end
    end
  end

  assign out_valid = vld[CORDIC_STEPS];
  assign out_x     = x[CORDIC_STEPS];
  assign out_y     = y[CORDIC_STEPS];
  assign out_tag   = tag[CORDIC_STEPS];

endmodule

FILE: rtl/core/rigid_rotation_inertia_terms.sv
// Top level: rotational inertia gradient and Hessian of a 2D rigid body.
`timescale 1ns / 1ps
// One item enters per cycle unless stalled, passing two reduction stages,
// the CORDIC pipeline and eight arithmetic stages. The whole pipeline
// advances together and holds when the output register is full and not
// taken, so a stall on the result side stalls the input side in the same
// cycle. The user must write registers through cfg_* only while no item is
// in flight; the block itself does not enforce this.
module rigid_rotation_inertia_terms
  import rrit_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // angle_now [31:0], angle_prev [63:32], spin_prev [95:64]
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rot_gradient [47:0], rot_hessian [95:48], saturated [96], zero [103:97]
  output logic [103:0] m_axis_tdata
);

  logic signed [31:0] inertia_xx, inertia_xy, inertia_yx, inertia_yy;
  logic [31:0]        time_step;
  logic               advance;

  // Whole pipeline moves when the output slot is free or being taken
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign cfg_ready     = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inertia_xx <= '0;
      inertia_xy <= '0;
      inertia_yx <= '0;
      inertia_yy <= '0;
      time_step  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IXX: inertia_xx <= cfg_data;
        REG_IXY: inertia_xy <= cfg_data;
        REG_IYX: inertia_yx <= cfg_data;
        REG_IYY: inertia_yy <= cfg_data;
        REG_DT:  time_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage r1: difference and first wrap. |phi| < 2^32, 2pi*3 > that range
  // is not enough for one step, so wrap by multiples chosen from a compare.
  logic               r1_valid;
  logic signed [34:0] r1_phi;
  logic signed [31:0] r1_spin;
  logic signed [34:0] diff;
  assign diff = 35'(signed'(s_axis_tdata[31:0])) - 35'(signed'(s_axis_tdata[63:32]));

  // phi in (-16,16) rad; at most 3 turns. Subtract 2 turns first if large.
  logic signed [34:0] diff_w;
  always_comb begin
    diff_w = diff;
    if (diff > 35'sd4216574282) diff_w = diff - 35'(TwoPiQ28 * 2);
    else if (diff < -35'sd4216574282) diff_w = diff + 35'(TwoPiQ28 * 2);
  end

  always_ff @(posedge clk) begin
    if (rst) r1_valid <= 1'b0;
    else if (advance) r1_valid <= s_axis_tvalid;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      r1_phi  <= diff_w;
      r1_spin <= s_axis_tdata[95:64];
    end
  end

  // Stage r2: finish wrap (at most two more turns) and fold into half-plane
  logic signed [34:0] w2, z2;
  logic               flip2;
  always_comb begin
    w2 = r1_phi;
    if (w2 > PiQ28) w2 = w2 - TwoPiQ28;
    else if (w2 < -PiQ28) w2 = w2 + TwoPiQ28;
    if (w2 > PiQ28) w2 = w2 - TwoPiQ28;
    else if (w2 < -PiQ28) w2 = w2 + TwoPiQ28;
    z2 = w2;
    flip2 = 1'b0;
    if (w2 > HalfPiQ28) begin
      z2 = w2 - PiQ28;
      flip2 = 1'b1;
    end else if (w2 < -HalfPiQ28) begin
      z2 = w2 + PiQ28;
      flip2 = 1'b1;
    end
  end

  logic               r2_valid;
  logic signed [34:0] r2_z;
  logic [32:0]        r2_tag;
  always_ff @(posedge clk) begin
    if (rst) r2_valid <= 1'b0;
    else if (advance) r2_valid <= r1_valid;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      r2_z   <= z2;
      r2_tag <= {flip2, r1_spin};
    end
  end

  // CORDIC pipeline
  logic               c_valid;
  logic signed [33:0] c_x, c_y;
  logic [32:0]        c_tag;
  rrit_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .TagWidth(33)) u_cordic (
    .clk(clk), .rst(rst), .advance(advance),
    .in_valid(r2_valid), .in_angle(r2_z), .in_tag(r2_tag),
    .out_valid(c_valid), .out_x(c_x), .out_y(c_y), .out_tag(c_tag)
  );

  // Stage a1: apply sign flip, tensor sums, dt*omega
  logic [6:0]         v;
  logic signed [34:0] a1_c, a1_s;
  logic signed [32:0] a1_a, a1_b, a1_d;
  logic signed [63:0] a1_dw;
  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (advance) v <= {v[5:0], c_valid};
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      a1_c  <= c_tag[32] ? -35'(c_x) : 35'(c_x);
      a1_s  <= c_tag[32] ? -35'(c_y) : 35'(c_y);
      a1_a  <= 33'(inertia_xx) + 33'(inertia_yy);
      a1_b  <= 33'(inertia_yx) - 33'(inertia_xy);
      a1_d  <= 33'(inertia_xy) - 33'(inertia_yx);
      a1_dw <= 64'(signed'({1'b0, time_step})) * 64'(signed'(c_tag[31:0]));
    end
  end

  // Stage a2: four products, floored by 2^6 (a product can reach 2^62)
  logic signed [63:0] a2_xa, a2_yb, a2_ya, a2_xd;
  logic signed [63:0] a2_dw;
  always_ff @(posedge clk) begin
    if (advance) begin
      a2_xa <= (64'(a1_c) * 64'(a1_a)) >>> 6;
      a2_yb <= (64'(a1_s) * 64'(a1_b)) >>> 6;
      a2_ya <= (64'(a1_s) * 64'(a1_a)) >>> 6;
      a2_xd <= (64'(a1_c) * 64'(a1_d)) >>> 6;
      a2_dw <= a1_dw;
    end
  end

  // Stage a3: P and Q in Q40
  logic signed [62:0] a3_p, a3_q;
  logic signed [63:0] a3_dw;
  always_ff @(posedge clk) begin
    if (advance) begin
      a3_p  <= 63'(a2_xa) + 63'(a2_yb);
      a3_q  <= 63'(a2_ya) + 63'(a2_xd);
      a3_dw <= a2_dw;
    end
  end

  // Stage a4: dw times P and Q as 32-bit partial products (lo/hi halves)
  logic [63:0]         a4_pll, a4_qll;   // low P/Q times low dw, unsigned
  logic signed [64:0]  a4_plh, a4_qlh;   // low P/Q times high dw
  logic signed [64:0]  a4_phl, a4_qhl;   // high P/Q times low dw
  logic signed [63:0]  a4_phh, a4_qhh;   // high P/Q times high dw
  logic signed [62:0]  a4_p, a4_q;
  always_ff @(posedge clk) begin
    if (advance) begin
      a4_pll <= 64'(a3_p[31:0]) * 64'(a3_dw[31:0]);
      a4_qll <= 64'(a3_q[31:0]) * 64'(a3_dw[31:0]);
      a4_plh <= 65'(signed'({1'b0, a3_p[31:0]})) * 65'(signed'(a3_dw[63:32]));
      a4_qlh <= 65'(signed'({1'b0, a3_q[31:0]})) * 65'(signed'(a3_dw[63:32]));
      a4_phl <= 65'(signed'(a3_p[62:32])) * 65'(signed'({1'b0, a3_dw[31:0]}));
      a4_qhl <= 65'(signed'(a3_q[62:32])) * 65'(signed'({1'b0, a3_dw[31:0]}));
      a4_phh <= 64'(signed'(a3_p[62:32])) * 64'(signed'(a3_dw[63:32]));
      a4_qhh <= 64'(signed'(a3_q[62:32])) * 64'(signed'(a3_dw[63:32]));
      a4_p   <= a3_p;
      a4_q   <= a3_q;
    end
  end

  // Stage a5: partial products combined in pairs
  logic signed [127:0] a5_mp0, a5_mp1, a5_mq0, a5_mq1;
  logic signed [62:0]  a5_p, a5_q;
  always_ff @(posedge clk) begin
    if (advance) begin
      a5_mp0 <= 128'(signed'({1'b0, a4_pll})) + (128'(a4_plh) <<< 32);
      a5_mp1 <= (128'(a4_phl) <<< 32) + (128'(a4_phh) <<< 64);
      a5_mq0 <= 128'(signed'({1'b0, a4_qll})) + (128'(a4_qlh) <<< 32);
      a5_mq1 <= (128'(a4_qhl) <<< 32) + (128'(a4_qhh) <<< 64);
      a5_p   <= a4_p;
      a5_q   <= a4_q;
    end
  end

  // Stage a6: final product sum and rounding of each term
  logic signed [55:0] a6_tp, a6_tq, a6_mp, a6_mq;
  logic signed [127:0] rmp, rmq;
  logic signed [62:0]  rp, rq;
  always_comb begin
    rmp = (a5_mp0 + a5_mp1 + (128'sd1 <<< 71)) >>> 72;
    rmq = (a5_mq0 + a5_mq1 + (128'sd1 <<< 71)) >>> 72;
    rp  = (a5_p + 63'sd32768) >>> 16;
    rq  = (a5_q + 63'sd32768) >>> 16;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      a6_mp <= rmp[55:0];
      a6_mq <= rmq[55:0];
      a6_tp <= 56'(rp);
      a6_tq <= 56'(rq);
    end
  end

  // Stage a7: gradient difference and Hessian sum
  logic signed [56:0] a7_g, a7_h;
  always_ff @(posedge clk) begin
    if (advance) begin
      a7_g <= 57'(a6_tq) - 57'(a6_mp);
      a7_h <= 57'(a6_tp) + 57'(a6_mq);
    end
  end

  // Stage a8: saturation into the output register
  logic signed [47:0] g_sat, h_sat;
  logic               g_clip, h_clip;
  always_comb begin
    g_clip = 1'b1;
    h_clip = 1'b1;
    if (a7_g > 57'(SatHi)) g_sat = SatHi;
    else if (a7_g < 57'(SatLo)) g_sat = SatLo;
    else begin
      g_sat  = a7_g[47:0];
      g_clip = 1'b0;
    end
    if (a7_h > 57'(SatHi)) h_sat = SatHi;
    else if (a7_h < 57'(SatLo)) h_sat = SatLo;
    else begin
      h_sat  = a7_h[47:0];
      h_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (advance) m_axis_tvalid <= v[6];
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {7'd0, g_clip | h_clip, h_sat, g_sat};
    end
  end

  // Output must hold while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  // Accepted input is never refused when pipeline is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output slot");
  // Padding bits above the flag stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[103:97] == 7'd0)
    else $error("padding bits not zero");

endmodule

FILE: verif/rigid_rotation_inertia_terms_tb.sv
// Testbench: self-checking stimulus and result check for the inertia-term pipeline.
`timescale 1ns / 1ps
module rigid_rotation_inertia_terms_tb
  import rrit_pkg::*;
;

  localparam int Steps    = CordicStepsDefault;
  localparam int Latency  = Steps + 10;
  localparam int WdLimit  = 20000;
  localparam int NumRand  = 800;

  typedef struct packed {
    logic [31:0] spin_prev;
    logic [31:0] angle_prev;
    logic [31:0] angle_now;
  } angle_item_t;

  typedef struct packed {
    logic        saturated;
    logic [47:0] rot_hessian;
    logic [47:0] rot_gradient;
  } inertia_res_t;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;

  rigid_rotation_inertia_terms #(.CORDIC_STEPS(Steps)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predictor copy of the register file
  logic [31:0] tensor_regs [5];

  angle_item_t  pending_items [$];
  inertia_res_t expected_terms [$];
  int  mismatch_count = 0;
  int  idle_cycles = 0;
  bit  quiet_mode = 0;      // no idling near the end
  bit  hold_sender = 0;     // pause input until drained
  bit  timed_out = 0;

  // Floor shift
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint arctan_q28(int i);
    longint unsigned acc;
    longint unsigned term;
    acc = 0;
    if (i == 0) return 64'sd210828714;
    for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
      term = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
      if (k % 2 == 1) acc -= term;
      else acc += term;
    end
    return longint'((acc + (64'd1 << 33)) >> 34);
  endfunction

  // round_half_up(a*b / 2^72)
  function automatic longint scaled_product(longint a, longint b);
    logic signed [127:0] prod;
    prod = 128'(signed'(a)) * 128'(signed'(b));
    prod = prod + (128'sd1 << 71);
    return longint'(prod >>> 72);
  endfunction

  function automatic longint clip48(longint v, ref bit flag);
    if (v > 64'sh7FFF_FFFF_FFFF) begin
      flag = 1;
      return 64'sh7FFF_FFFF_FFFF;
    end
    if (v < -64'sh8000_0000_0000) begin
      flag = 1;
      return -64'sh8000_0000_0000;
    end
    return v;
  endfunction

  function automatic inertia_res_t predict_inertia_terms(angle_item_t it);
    longint phi, z, x, y, xs, ys, a, b, d, p40, q40, dw, grad, hess, omega, dt;
    longint ixx, ixy, iyx, iyy;
    bit flip, flag;
    inertia_res_t r;
    phi = longint'(signed'(it.angle_now)) - longint'(signed'(it.angle_prev));
    omega = longint'(signed'(it.spin_prev));
    ixx = longint'(signed'(tensor_regs[REG_IXX]));
    ixy = longint'(signed'(tensor_regs[REG_IXY]));
    iyx = longint'(signed'(tensor_regs[REG_IYX]));
    iyy = longint'(signed'(tensor_regs[REG_IYY]));
    dt = longint'({32'd0, tensor_regs[REG_DT]});
    flip = 0;
    flag = 0;
    x = GainQ30;
    y = 0;
    while (phi > PiQ28) phi -= TwoPiQ28;
    while (phi < -PiQ28) phi += TwoPiQ28;
    z = phi;
    if (phi > HalfPiQ28) begin
      z = phi - PiQ28;
      flip = 1;
    end else if (phi < -HalfPiQ28) begin
      z = phi + PiQ28;
      flip = 1;
    end
    for (int i = 0; i < Steps; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_q28(i);
      end else begin
        x += ys; y -= xs; z += arctan_q28(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    a = ixx + iyy;
    b = iyx - ixy;
    d = ixy - iyx;
    p40 = floor_shr(x * a, 6) + floor_shr(y * b, 6);
    q40 = floor_shr(y * a, 6) + floor_shr(x * d, 6);
    dw = dt * omega;
    grad = floor_shr(q40 + (64'sd1 <<< 15), 16) - scaled_product(dw, p40);
    hess = floor_shr(p40 + (64'sd1 <<< 15), 16) + scaled_product(dw, q40);
    grad = clip48(grad, flag);
    hess = clip48(hess, flag);
    r.rot_gradient = grad[47:0];
    r.rot_hessian = hess[47:0];
    r.saturated = flag;
    return r;
  endfunction

  // Input driver
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_terms.push_back(predict_inertia_terms(angle_item_t'(s_axis_tdata)));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
          src_gap <= $urandom_range(1, 9) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0 && !hold_sender) begin
          s_axis_tdata <= pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: backpressure and check
  int sink_gap = 0;
  always @(posedge clk) begin
    inertia_res_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = inertia_res_t'(m_axis_tdata[96:0]);
        if (expected_terms.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result %h", m_axis_tdata);
        end else begin
          want = expected_terms.pop_front();
          if (got !== want || m_axis_tdata[103:97] !== 7'd0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: grad exp %h got %h, hess exp %h got %h, sat exp %b got %b",
                       want.rot_gradient, got.rot_gradient, want.rot_hessian,
                       got.rot_hessian, want.saturated, got.saturated);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        sink_gap <= $urandom_range(1, 9) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on transaction-free cycles
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WdLimit && !timed_out) begin
        timed_out = 1;
        $display("rigid_rotation_inertia_terms_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    tensor_regs[idx] = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_tensor(logic [31:0] xx, logic [31:0] xy, logic [31:0] yx,
                            logic [31:0] yy, logic [31:0] dt);
    write_reg(REG_IXX, xx);
    write_reg(REG_IXY, xy);
    write_reg(REG_IYX, yx);
    write_reg(REG_IYY, yy);
    write_reg(REG_DT, dt);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_terms.size() > 0)
      @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 3) - 1;
      3: return {{20{$urandom_range(0, 1) == 1}}, 12'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_item(logic [31:0] now, logic [31:0] prv, logic [31:0] spin);
    angle_item_t it;
    it.angle_now = now;
    it.angle_prev = prv;
    it.spin_prev = spin;
    pending_items.push_back(it);
  endtask

  // Random tensor: mostly moderate values, some full-range words
  task automatic random_tensor();
    logic [31:0] v [5];
    for (int i = 0; i < 5; i++) v[i] = ($urandom_range(0, 3) == 0) ? $urandom : rand_word() >>> 8;
    v[4] = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 32'h0100_0000);
    set_tensor(v[0], v[1], v[2], v[3], v[4]);
  endtask

  initial begin
    for (int i = 0; i < 5; i++) tensor_regs[i] = '0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset values: tensor zero
    queue_item(32'h1000_0000, 32'h0, 32'h0100_0000);
    wait_drained();

    // Directed: angle extremes, quadrants, wraps
    set_tensor(32'h0001_0000, 32'h0000_8000, 32'hFFFF_C000, 32'h0002_0000, 32'h1000_0000);
    queue_item(32'h0, 32'h0, 32'h0);
    queue_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_item(32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    queue_item(32'h8000_0000, 32'h0, 32'h0100_0000);
    queue_item(32'd843314857, 32'h0, 32'h0);
    queue_item(32'd843314858, 32'h0, 32'h0);
    queue_item(-32'sd843314858, 32'h0, 32'h0);
    queue_item(32'd421657428, 32'h0, 32'h0);
    queue_item(32'd421657429, 32'h0, 32'h0);
    queue_item(-32'sd421657429, 32'h0, 32'h0);
    queue_item(32'h0, 32'h7FFF_FFFF, 32'hFF00_0000);
    wait_drained();

    // Extreme tensor and dt: saturation
    set_tensor(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_item(32'h0, 32'h0, 32'h7FFF_FFFF);
    queue_item(32'h0, 32'h0, 32'h8000_0000);
    queue_item(32'h1000_0000, 32'h0, 32'h8000_0000);
    queue_item(32'h3000_0000, 32'h0, 32'h7FFF_FFFF);
    wait_drained();
    set_tensor(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0);
    queue_item(32'h2000_0000, 32'hE000_0000, 32'h7FFF_FFFF);
    queue_item(32'hC000_0000, 32'h0, 32'h8000_0000);
    wait_drained();

    // Random phases with varying configuration
    for (int ph = 0; ph < 8; ph++) begin
      random_tensor();
      if (ph == 7) quiet_mode = 1;
      for (int n = 0; n < NumRand / 8; n++) begin
        if ($urandom_range(0, 1) == 0)
          queue_item($urandom, $urandom, rand_word());
        else
          queue_item(rand_word(), rand_word(), $urandom);
      end
      if (ph == 3) begin
        // Hold input until results drain mid-phase
        while (pending_items.size() > NumRand / 16) @(posedge clk);
        hold_sender = 1;
        while (s_axis_tvalid || expected_terms.size() > 0) @(posedge clk);
        hold_sender = 0;
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("rigid_rotation_inertia_terms_tb OK");
    end else begin
      $display("rigid_rotation_inertia_terms_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rrit_pkg.sv
rtl/core/rrit_cordic.sv
rtl/core/rigid_rotation_inertia_terms.sv
verif/rigid_rotation_inertia_terms_tb.sv
